FILE: src/bsad_pkg.sv
package bsad_pkg;

  // Store geometry
  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register indexes (word index = paddr[2])
  localparam logic REG_DESCENDING = 1'b0;

  // Sequencer states
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_LOAD       = 3'd0;
  localparam logic [ST_W-1:0] S_PASS_START = 3'd1;
  localparam logic [ST_W-1:0] S_PASS_FIRST = 3'd2;
  localparam logic [ST_W-1:0] S_STEP       = 3'd3;
  localparam logic [ST_W-1:0] S_PASS_END   = 3'd4;
  localparam logic [ST_W-1:0] S_OUT_READ   = 3'd5;
  localparam logic [ST_W-1:0] S_OUT_LOAD   = 3'd6;
  localparam logic [ST_W-1:0] S_OUT_WAIT   = 3'd7;

endpackage

FILE: src/bsad_ram.sv
module bsad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/bubble_sort_asc_desc_top.sv
// Bubble sort block with selectable direction.
// Input channel (value_i, last_i; in_valid_i / in_ready_o): each accepted
// request stores one signed 32-bit value, one request per cycle while in_ready_o
// is high. Values past MAX_ITEMS are dropped; last_i still ends the set.
// A request with last_i set starts the sort: one shared comparator walks the
// element RAM, one compare-swap per cycle, in passes that shrink by one.
// Output channel (sorted_value_o, end_of_set_o; out_valid_o / out_ready_i):
// results leave in order, each read, registered and held until taken; the
// last one carries end_of_set_o. A stalled receiver simply holds the block.
// in_ready_o is low from the last request until the final result is taken.
// APB register 0 (descending): 0 ascending, 1 descending; write it while idle.
// Reset clears the element count, the direction and the sequencer; no
// clearing pass is needed since only entries of the current set are read.
module bubble_sort_asc_desc_top
  import bsad_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     last_i,
  // Output channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] sorted_value_o,
  output logic                     end_of_set_o,
  // Configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  logic [ST_W-1:0]   state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [IDX_W-1:0]  pend_q, pend_d;
  logic [DATA_W-1:0] carry_q, carry_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;
  logic              out_last_q, out_last_d;
  logic              desc_q;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              in_acc;
  logic [CNT_W-1:0]  cnt_new;
  logic              swap;

  assign in_acc = in_valid_i && in_ready_o;

  // Element store
  bsad_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_ITEMS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DESCENDING) ? {{(PDATA_W-1){1'b0}}, desc_q}
                                               : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DESCENDING)) begin
      desc_q <= pwdata[0];
    end
  end

  // Shared comparator: move the carried element forward when it belongs later
  assign swap = desc_q ? ($signed(ram_rdata) > $signed(carry_q))
                       : ($signed(carry_q) > $signed(ram_rdata));

  // Count after the current request
  assign cnt_new = (count_q < CNT_W'(MAX_ITEMS)) ? count_q + CNT_W'(1) : count_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    k_d         = k_q;
    pend_d      = pend_q;
    carry_d     = carry_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[IDX_W-1:0];
    ram_wdata   = value_i;
    ram_raddr   = k_q;
    in_ready_o  = 1'b0;

    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          // Store unless full; drop otherwise
          ram_we  = (count_q < CNT_W'(MAX_ITEMS));
          count_d = cnt_new;
          if (last_i) begin
            k_d = '0;
            if (cnt_new >= CNT_W'(2)) begin
              pend_d  = IDX_W'(cnt_new - CNT_W'(1));
              state_d = S_PASS_START;
            end else if (cnt_new == CNT_W'(1)) begin
              state_d = S_OUT_READ;
            end else begin
              count_d = '0;
            end
          end
        end
      end
      S_PASS_START: begin
        ram_raddr = '0;
        state_d   = S_PASS_FIRST;
      end
      S_PASS_FIRST: begin
        // Pick up the head element, fetch its neighbor
        carry_d   = ram_rdata;
        ram_raddr = IDX_W'(1);
        k_d       = '0;
        state_d   = S_STEP;
      end
      S_STEP: begin
        ram_we    = 1'b1;
        ram_waddr = k_q;
        ram_raddr = k_q + IDX_W'(2);
        if (swap) begin
          ram_wdata = ram_rdata;
        end else begin
          ram_wdata = carry_q;
          carry_d   = ram_rdata;
        end
        if (k_q + IDX_W'(1) == pend_q) begin
          state_d = S_PASS_END;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      S_PASS_END: begin
        // Drop the carried element at the pass end, start the next pass
        ram_we    = 1'b1;
        ram_waddr = pend_q;
        ram_wdata = carry_q;
        ram_raddr = '0;
        pend_d    = pend_q - IDX_W'(1);
        k_d       = '0;
        if (pend_q == IDX_W'(1)) begin
          state_d = S_OUT_READ;
        end else begin
          state_d = S_PASS_FIRST;
        end
      end
      S_OUT_READ: begin
        ram_raddr = k_q;
        state_d   = S_OUT_LOAD;
      end
      S_OUT_LOAD: begin
        out_valid_d = 1'b1;
        out_value_d = ram_rdata;
        out_last_d  = ({1'b0, k_q} == count_q - CNT_W'(1));
        state_d     = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        // Hold the result until the receiver takes it
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            count_d = '0;
            state_d = S_LOAD;
          end else begin
            k_d     = k_q + IDX_W'(1);
            state_d = S_OUT_READ;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      k_q         <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      k_q         <= k_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    carry_q     <= carry_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign end_of_set_o   = out_last_q;

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output active together");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ITEMS))
    else $error("element count beyond store size");

  a_set_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && end_of_set_o) |=> (in_ready_o && count_q == '0))
    else $error("block not idle after final result");

  a_load_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD && ram_we) |-> in_valid_i)
    else $error("store written without a request");

  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |-> (k_q < pend_q))
    else $error("compare step past pass end");
`endif

endmodule
